@@ design/per_class_box_nms_assert.svh @@
// assertion macros used by the back-end design file pcbn_back
`ifndef PER_CLASS_BOX_NMS_ASSERT_SVH
`define PER_CLASS_BOX_NMS_ASSERT_SVH
// implication checked every clock outside reset
`define PCBN_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define PCBN_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ design/pcbn_pkg.sv @@
// shared types and constants of the box suppression block
package pcbn_pkg;
    localparam int MaxBoxesDefault   = 32;
    localparam int NumClassesDefault = 80;
    localparam int CoordW = 20;
    localparam int ScoreW = 16;
    localparam int LabelW = 7;
    localparam int ThrW   = 16;
    localparam int DimW   = 14;
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_THR = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FW  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FH  = 2'd2;
    localparam logic [ThrW-1:0] THR_RESET = 16'd29491;
    localparam logic [DimW-1:0] FW_RESET  = 14'd640;
    localparam logic [DimW-1:0] FH_RESET  = 14'd480;

    typedef struct packed {
        logic                     box_valid;
        logic signed [CoordW-1:0] x_min;
        logic signed [CoordW-1:0] y_min;
        logic signed [CoordW-1:0] x_max;
        logic signed [CoordW-1:0] y_max;
        logic [ScoreW-1:0]        score;
        logic [LabelW-1:0]        label;
        logic                     frame_last;
    } in_item_t;

    typedef struct packed {
        logic signed [CoordW-1:0] x_min;
        logic signed [CoordW-1:0] y_min;
        logic signed [CoordW-1:0] x_max;
        logic signed [CoordW-1:0] y_max;
        logic [ScoreW-1:0]        score;
        logic [LabelW-1:0]        label;
        logic                     frame_end;
        logic                     dropped;
    } out_item_t;

    // classified word passed from front to back
    typedef struct packed {
        logic                     store;
        logic                     drop;
        logic                     frame_last;
        logic signed [CoordW-1:0] x_min;
        logic signed [CoordW-1:0] y_min;
        logic signed [CoordW-1:0] x_max;
        logic signed [CoordW-1:0] y_max;
        logic [ScoreW-1:0]        score;
        logic [LabelW-1:0]        label;
    } cls_word_t;

    typedef enum logic [3:0] {
        ST_LOAD, ST_CLASS, ST_PICK, ST_SCAN, ST_RD, ST_M1, ST_M2, ST_CMP,
        ST_KEEP, ST_EMIT, ST_END
    } back_state_t;
endpackage

@@ design/pcbn_front.sv @@
// input side: checks label range and drives the word queue
module pcbn_front #(
    parameter int NUM_CLASSES = pcbn_pkg::NumClassesDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pcbn_pkg::in_item_t  in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output pcbn_pkg::cls_word_t q_word
);
    import pcbn_pkg::*;
    localparam int Depth = 2;
    cls_word_t    mem_reg [Depth];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    cls_word_t    w;
    logic         push, pop, bad;

    always_comb
    begin
        bad = {1'b0, in_item.label} >= 8'(NUM_CLASSES);
        w.store = in_item.box_valid && !bad;
        w.drop  = in_item.box_valid && bad;
        w.frame_last = in_item.frame_last;
        w.x_min = in_item.x_min;
        w.y_min = in_item.y_min;
        w.x_max = in_item.x_max;
        w.y_max = in_item.y_max;
        w.score = in_item.score;
        w.label = in_item.label;
    end

    assign in_ready = cnt_reg != 2'(Depth);
    assign q_valid  = cnt_reg != 2'd0;
    assign q_word   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ design/pcbn_back.sv @@
// store, per-class ranking, suppression and output register
module pcbn_back #(
    parameter int MAX_BOXES   = pcbn_pkg::MaxBoxesDefault,
    parameter int NUM_CLASSES = pcbn_pkg::NumClassesDefault
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  pcbn_pkg::cls_word_t       q_word,
    input  logic [pcbn_pkg::ThrW-1:0] thr,
    input  logic [pcbn_pkg::DimW-1:0] fw,
    input  logic [pcbn_pkg::DimW-1:0] fh,
    output logic                      o_valid,
    input  logic                      o_ready,
    output pcbn_pkg::out_item_t       o_item,
    output logic                      o_last
);
    import pcbn_pkg::*;
    `include "per_class_box_nms_assert.svh"
    localparam int IdxW = $clog2(MAX_BOXES);
    localparam int CntW = $clog2(MAX_BOXES + 1);
    localparam int ClsW = $clog2(NUM_CLASSES + 1);

    logic [2*CoordW-1:0]      xs_mem [MAX_BOXES];
    logic [2*CoordW-1:0]      ys_mem [MAX_BOXES];
    logic [ScoreW+LabelW-1:0] sl_mem [MAX_BOXES];

    back_state_t st_reg, st_next;
    logic [CntW-1:0]    cnt_reg;
    logic               drop_reg;
    logic [MAX_BOXES-1:0] kept_reg, done_reg;
    logic [ClsW-1:0]    cls_reg;
    logic [CntW-1:0]    i_reg;
    logic               found_reg;
    logic [IdxW-1:0]    best_reg, a_reg, j_reg;
    logic [ScoreW-1:0]  bests_reg;
    logic               pass_reg;
    // operands for pair test
    logic signed [CoordW-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic signed [CoordW+1:0] ovx_reg, ovy_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic signed [2*CoordW+3:0] ov_reg, ua_reg, ub_reg;
    logic signed [2*CoordW+5:0] uni_reg;
    logic signed [2*CoordW+4:0] ovs_reg;
    logic [2*CoordW-1:0] xa_rd, ya_rd;
    logic [ScoreW+LabelW-1:0] sl_rd;
    out_item_t            oi_reg;
    logic                 ov_reg_v, ol_reg;

    logic [IdxW-1:0] ii;
    logic [ScoreW-1:0] si;
    logic [LabelW-1:0] li;
    logic cand, jcls, fail_cmp, emit_go, end_go;
    logic signed [CoordW-1:0] rx0, rx1, ry0, ry1, cx1, cy1;
    logic signed [CoordW+1:0] wlim, hlim;

    assign ii = i_reg[IdxW-1:0];
    assign si = sl_mem[ii][ScoreW+LabelW-1:LabelW];
    assign li = sl_mem[ii][LabelW-1:0];
    assign cand = (i_reg < cnt_reg) && ({1'b0, li} == 8'(cls_reg)) && !done_reg[ii];
    assign jcls = ({1'b0, sl_mem[j_reg][LabelW-1:0]} == 8'(cls_reg));
    assign q_ready = (st_reg == ST_LOAD);
    assign o_valid = ov_reg_v;
    assign o_item = oi_reg;
    assign o_last = ol_reg;
    assign wlim = {4'b0, fw, 4'b0};
    assign hlim = {4'b0, fh, 4'b0};

    function automatic logic signed [CoordW+1:0] span(
        input logic signed [CoordW-1:0] a0, a1, b0, b1);
        logic signed [CoordW-1:0] lo, hi_a, lo_b, hi_b, m;
        begin
            if (a0 > b0)
            begin
                lo = b0; hi_a = b1; lo_b = a0; hi_b = a1;
            end
            else
            begin
                lo = a0; hi_a = a1; lo_b = b0; hi_b = b1;
            end
            m = (hi_a < hi_b) ? hi_a : hi_b;
            if (hi_a < lo_b)
                span = '0;
            else
                span = (CoordW+2)'(m) - (CoordW+2)'(lo_b);
            if (lo > lo_b)
                span = '0;
        end
    endfunction

    always_comb
    begin
        ax0 = xa_rd[2*CoordW-1:CoordW]; ax1 = xa_rd[CoordW-1:0];
        ay0 = ya_rd[2*CoordW-1:CoordW]; ay1 = ya_rd[CoordW-1:0];
        bx0 = xs_mem[j_reg][2*CoordW-1:CoordW]; bx1 = xs_mem[j_reg][CoordW-1:0];
        by0 = ys_mem[j_reg][2*CoordW-1:CoordW]; by1 = ys_mem[j_reg][CoordW-1:0];
        rx0 = ax0; rx1 = ax1; ry0 = ay0; ry1 = ay1;
        cx1 = ((CoordW+2)'(rx1) > wlim) ? CoordW'(wlim) : rx1;
        cy1 = ((CoordW+2)'(ry1) > hlim) ? CoordW'(hlim) : ry1;
        fail_cmp = uni_reg != '0 &&
                   ((2*CoordW+22)'(ovs_reg) <<< 16) >
                   (2*CoordW+22)'($signed({1'b0, thr})) * (2*CoordW+22)'(uni_reg);
        emit_go = (st_reg == ST_EMIT) && (!ov_reg_v || o_ready) && pass_reg
                  && rx0 < rx1 && ry0 < ry1;
        end_go = (st_reg == ST_END) && (!ov_reg_v || o_ready);
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_LOAD:  if (q_valid && q_word.frame_last) st_next = ST_CLASS;
            ST_CLASS: st_next = (cls_reg == ClsW'(NUM_CLASSES)) ? ST_END : ST_PICK;
            ST_PICK:  if (i_reg == CntW'(MAX_BOXES) || i_reg >= cnt_reg)
                          st_next = found_reg ? ST_SCAN : ST_CLASS;
            ST_SCAN:  if ({1'b0, j_reg} >= cnt_reg || !pass_reg)
                          st_next = ST_KEEP;
                      else if (kept_reg[j_reg] && jcls)
                          st_next = ST_RD;
                      else if (j_reg == IdxW'(MAX_BOXES - 1))
                          st_next = ST_KEEP;
            ST_RD:    st_next = ST_M1;
            ST_M1:    st_next = ST_M2;
            ST_M2:    st_next = ST_CMP;
            ST_CMP:   st_next = (j_reg == IdxW'(MAX_BOXES - 1)) ? ST_KEEP : ST_SCAN;
            ST_KEEP:  st_next = ST_EMIT;
            ST_EMIT:  if (!ov_reg_v || o_ready) st_next = ST_PICK;
            ST_END:   if (!ov_reg_v || o_ready) st_next = ST_LOAD;
            default:  st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_LOAD && q_valid && q_word.store && cnt_reg < CntW'(MAX_BOXES))
        begin
            xs_mem[cnt_reg[IdxW-1:0]] <= {q_word.x_min, q_word.x_max};
            ys_mem[cnt_reg[IdxW-1:0]] <= {q_word.y_min, q_word.y_max};
            sl_mem[cnt_reg[IdxW-1:0]] <= {q_word.score, q_word.label};
        end
        xa_rd <= xs_mem[a_reg];
        ya_rd <= ys_mem[a_reg];
        sl_rd <= sl_mem[a_reg];
        ovx_reg <= span(ax0, ax1, bx0, bx1);
        ovy_reg <= span(ay0, ay1, by0, by1);
        aw_reg <= (CoordW+2)'(ax1) - (CoordW+2)'(ax0);
        ah_reg <= (CoordW+2)'(ay1) - (CoordW+2)'(ay0);
        bw_reg <= (CoordW+2)'(bx1) - (CoordW+2)'(bx0);
        bh_reg <= (CoordW+2)'(by1) - (CoordW+2)'(by0);
        ov_reg <= ovx_reg * ovy_reg;
        ua_reg <= aw_reg * ah_reg;
        ub_reg <= bw_reg * bh_reg;
        uni_reg <= (2*CoordW+6)'(ua_reg) + (2*CoordW+6)'(ub_reg) - (2*CoordW+6)'(ov_reg);
        ovs_reg <= (2*CoordW+5)'(ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_LOAD;
            cnt_reg <= '0;
            drop_reg <= 1'b0;
            kept_reg <= '0;
            done_reg <= '0;
            cls_reg <= '0;
            i_reg <= '0;
            found_reg <= 1'b0;
            best_reg <= '0;
            bests_reg <= '0;
            a_reg <= '0;
            j_reg <= '0;
            pass_reg <= 1'b1;
            ov_reg_v <= 1'b0;
            ol_reg <= 1'b0;
            oi_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (emit_go || end_go)
                ov_reg_v <= 1'b1;
            else if (o_ready)
                ov_reg_v <= 1'b0;
            unique case (st_reg)
                ST_LOAD:
                begin
                    if (q_valid)
                    begin
                        if (q_word.drop || (q_word.store && cnt_reg == CntW'(MAX_BOXES)))
                            drop_reg <= 1'b1;
                        else if (q_word.store)
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    cls_reg <= '0;
                    kept_reg <= '0;
                    done_reg <= '0;
                    i_reg <= '0;
                    found_reg <= 1'b0;
                end
                ST_CLASS:
                begin
                    i_reg <= '0;
                    found_reg <= 1'b0;
                end
                ST_PICK:
                begin
                    if (i_reg == CntW'(MAX_BOXES) || i_reg >= cnt_reg)
                    begin
                        i_reg <= '0;
                        if (found_reg)
                        begin
                            a_reg <= best_reg;
                            done_reg[best_reg] <= 1'b1;
                            j_reg <= '0;
                            pass_reg <= 1'b1;
                        end
                        else
                            cls_reg <= cls_reg + 1'b1;
                    end
                    else
                    begin
                        if (cand && (!found_reg || si > bests_reg))
                        begin
                            found_reg <= 1'b1;
                            best_reg <= ii;
                            bests_reg <= si;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (st_next == ST_SCAN)
                        j_reg <= j_reg + 1'b1;
                end
                ST_CMP:
                begin
                    if (fail_cmp)
                        pass_reg <= 1'b0;
                    if (j_reg != IdxW'(MAX_BOXES - 1))
                        j_reg <= j_reg + 1'b1;
                end
                ST_KEEP:
                begin
                    found_reg <= 1'b0;
                    if (pass_reg)
                        kept_reg[a_reg] <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        ol_reg <= 1'b0;
                        oi_reg <= out_item_t'({rx0, ry0, cx1, cy1, sl_rd, 2'b00});
                    end
                end
                ST_END:
                begin
                    if (end_go)
                    begin
                        ol_reg <= 1'b1;
                        oi_reg <= out_item_t'({{(4*CoordW+ScoreW+LabelW){1'b0}},
                                               1'b1, drop_reg});
                        cnt_reg <= '0;
                        drop_reg <= 1'b0;
                        kept_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    `PCBN_ASSERT_IMP(a_cnt_max, 1'b1, cnt_reg <= CntW'(MAX_BOXES))
    `PCBN_ASSERT_IMP(a_last_end, o_valid && o_last, o_item.frame_end)
    `PCBN_ASSERT_NEXT(a_end_clr, st_reg == ST_END && (!ov_reg_v || o_ready),
                      cnt_reg == '0 && !drop_reg)
endmodule

@@ design/per_class_box_nms.sv @@
// Class-wise greedy box suppression. Boxes load one word per cycle into a
// MAX_BOXES-entry store behind a two-word queue; the word with tlast starts the
// pass and no further word enters the store until the end record is in the
// output register. For each class a selection sweep over the stored boxes
// picks the next candidate by descending score, and one more sweep finds the
// class used up. A candidate then scans the store entry by entry, running the
// pair test (operand stage, multiply, union sum, compare) against each earlier
// kept box of its class until one suppresses it; it is then recorded and, if
// kept with a non-empty box, emitted. Results leave in ascending class order
// and descending score, ended by a record with frame_end and tlast set.
module per_class_box_nms #(
    parameter int MAX_BOXES   = pcbn_pkg::MaxBoxesDefault,
    parameter int NUM_CLASSES = pcbn_pkg::NumClassesDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_min, y_min, x_max, y_max, score, label, zero pad
    input  logic [103:0] s_tdata,
    // box_valid
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x_min, out_y_min, out_x_max, out_y_max, out_score, out_label, dropped
    output logic [103:0] m_tdata,
    // frame_end
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [pcbn_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [15:0]  cfg_data
);
    import pcbn_pkg::*;
    logic [ThrW-1:0] thr_reg;
    logic [DimW-1:0] fw_reg, fh_reg;
    in_item_t  it;
    cls_word_t qw;
    out_item_t oi;
    logic qv, qr;

    always_comb
    begin
        it.box_valid = s_tuser;
        it.x_min = s_tdata[19:0];
        it.y_min = s_tdata[39:20];
        it.x_max = s_tdata[59:40];
        it.y_max = s_tdata[79:60];
        it.score = s_tdata[95:80];
        it.label = s_tdata[102:96];
        it.frame_last = s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            fw_reg <= FW_RESET;
            fh_reg <= FH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THR: thr_reg <= cfg_data;
                CFG_FW:  fw_reg <= cfg_data[DimW-1:0];
                CFG_FH:  fh_reg <= cfg_data[DimW-1:0];
                default: ;
            endcase
        end
    end

    pcbn_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(it), .q_valid(qv), .q_ready(qr), .q_word(qw));

    pcbn_back #(.MAX_BOXES(MAX_BOXES), .NUM_CLASSES(NUM_CLASSES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_ready(qr), .q_word(qw),
        .thr(thr_reg), .fw(fw_reg), .fh(fh_reg), .o_valid(m_tvalid),
        .o_ready(m_tready), .o_item(oi), .o_last(m_tlast));

    assign m_tdata = {oi.dropped, oi.label, oi.score, oi.y_max, oi.x_max,
                      oi.y_min, oi.x_min};
    assign m_tuser = oi.frame_end;
endmodule

@@ dv/tb_per_class_box_nms.sv @@
// testbench for the per-class box suppression block: self-predicting, randomized
`timescale 1ns / 100ps

module tb_per_class_box_nms;
    import pcbn_pkg::*;

    localparam int NBOX = 32;
    localparam int NCLS = 80;
    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        out_item_t rec;
        logic      last;
    } nms_rec_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = CFG_THR;
    logic [15:0]  cfg_data = '0;

    // predictor state
    logic signed [CoordW-1:0] bx0 [NBOX];
    logic signed [CoordW-1:0] by0 [NBOX];
    logic signed [CoordW-1:0] bx1 [NBOX];
    logic signed [CoordW-1:0] by1 [NBOX];
    logic [ScoreW-1:0] bscore [NBOX];
    logic [LabelW-1:0] blabel [NBOX];
    int   n_stored = 0;
    logic lost_box = 1'b0;
    logic [ThrW-1:0] thr = THR_RESET;
    logic [DimW-1:0] fw = FW_RESET;
    logic [DimW-1:0] fh = FH_RESET;

    nms_rec_t kept_q[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   hold_cycles = 0;
    int   stall_mode = 0;

    per_class_box_nms u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint span_ov(longint a0, longint a1, longint b0, longint b1);
        longint t;
        if (a0 > b0)
        begin
            t = a0; a0 = b0; b0 = t;
            t = a1; a1 = b1; b1 = t;
        end
        if (a1 < b0)
            return 0;
        return ((a1 < b1) ? a1 : b1) - b0;
    endfunction

    function automatic bit survives(int a, int b);
        longint ov, uni;
        ov = span_ov(bx0[a], bx1[a], bx0[b], bx1[b]) * span_ov(by0[a], by1[a], by0[b], by1[b]);
        uni = (longint'(bx1[a]) - bx0[a]) * (longint'(by1[a]) - by0[a])
            + (longint'(bx1[b]) - bx0[b]) * (longint'(by1[b]) - by0[b]) - ov;
        if (uni == 0)
            return 1'b1;
        return ov * 65536 <= longint'(thr) * uni;
    endfunction

    task automatic suppress_frame();
        int rank[NBOX];
        bit kept[NBOX];
        int m, k, t;
        bit keep;
        longint wlim, hlim, xr, yb;
        nms_rec_t r;
        wlim = longint'(fw) * 16;
        hlim = longint'(fh) * 16;
        foreach (kept[i]) kept[i] = 1'b0;
        for (int c = 0; c < NCLS; c++)
        begin
            m = 0;
            for (int i = 0; i < n_stored; i++)
            begin
                if (blabel[i] != c)
                    continue;
                k = m;
                while (k > 0 && bscore[rank[k-1]] < bscore[i])
                begin
                    rank[k] = rank[k-1];
                    k--;
                end
                rank[k] = i;
                m++;
            end
            for (k = 0; k < m; k++)
            begin
                t = rank[k];
                keep = 1'b1;
                for (int j = 0; j < n_stored && keep; j++)
                    if (kept[j] && blabel[j] == c)
                        keep = survives(t, j);
                if (!keep)
                    continue;
                kept[t] = 1'b1;
                if (by0[t] >= by1[t] || bx0[t] >= bx1[t])
                    continue;
                xr = (bx1[t] > wlim) ? wlim : bx1[t];
                yb = (by1[t] > hlim) ? hlim : by1[t];
                r.rec = '0;
                r.rec.x_min = bx0[t];
                r.rec.y_min = by0[t];
                r.rec.x_max = xr[CoordW-1:0];
                r.rec.y_max = yb[CoordW-1:0];
                r.rec.score = bscore[t];
                r.rec.label = c[LabelW-1:0];
                r.last = 1'b0;
                kept_q.insert(kept_q.size(), r);
            end
        end
        r.rec = '0;
        r.rec.frame_end = 1'b1;
        r.rec.dropped = lost_box;
        r.last = 1'b1;
        kept_q.insert(kept_q.size(), r);
        n_stored = 0;
        lost_box = 1'b0;
    endtask

    task automatic take_box(in_item_t b);
        if (b.box_valid)
        begin
            if (b.label >= NCLS || n_stored >= NBOX)
                lost_box = 1'b1;
            else
            begin
                bx0[n_stored] = b.x_min;
                by0[n_stored] = b.y_min;
                bx1[n_stored] = b.x_max;
                by1[n_stored] = b.y_max;
                bscore[n_stored] = b.score;
                blabel[n_stored] = b.label;
                n_stored++;
            end
        end
        if (b.frame_last)
            suppress_frame();
    endtask

    task automatic send_box(in_item_t b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {1'b0, b.label, b.score, b.y_max, b.x_max, b.y_min, b.x_min};
        s_tuser = b.box_valid;
        s_tlast = b.frame_last;
        do
            @(posedge clk);
        while (!s_tready);
        take_box(b);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        wait (kept_q.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[15:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_THR: thr = val[ThrW-1:0];
            CFG_FW:  fw = val[DimW-1:0];
            CFG_FH:  fh = val[DimW-1:0];
            default: ;
        endcase
    endtask

    function automatic in_item_t make_box(int cls, int cx, int cy, bit fl);
        in_item_t b;
        int w, h;
        w = $urandom_range(16, 2000);
        h = $urandom_range(16, 2000);
        b.box_valid = 1'b1;
        b.x_min = CoordW'(cx + int'($urandom_range(0, 400)) - 200);
        b.y_min = CoordW'(cy + int'($urandom_range(0, 400)) - 200);
        b.x_max = CoordW'(b.x_min + w);
        b.y_max = CoordW'(b.y_min + h);
        b.score = ($urandom_range(0, 3) == 0) ? 16'(cls * 7) : 16'($urandom);
        b.label = cls[LabelW-1:0];
        b.frame_last = fl;
        return b;
    endfunction

    function automatic in_item_t wild_box(bit fl);
        in_item_t b;
        b = '0;
        b.box_valid = 1'b1;
        b.x_min = CoordW'($urandom);
        b.y_min = CoordW'($urandom);
        b.x_max = CoordW'($urandom);
        b.y_max = CoordW'($urandom);
        b.score = ScoreW'($urandom);
        b.label = LabelW'($urandom);
        b.frame_last = fl;
        return b;
    endfunction

    task automatic test_directed();
        in_item_t b;
        b = '0;
        b.frame_last = 1'b1;
        send_box(b);                                   // empty frame
        b = '0;
        send_box(b);                                   // empty word, no result
        b = '{1'b1, -20'sd524288, -20'sd524288, 20'sd524287, 20'sd524287, 16'hffff, 7'd0, 1'b0};
        send_box(b);
        b = '{1'b1, -20'sd100, -20'sd100, 20'sd20000, 20'sd20000, 16'hffff, 7'd0, 1'b0};
        send_box(b);                                   // tie on score
        b = '{1'b1, 20'sd0, 20'sd0, 20'sd160, 20'sd160, 16'd0, 7'd79, 1'b0};
        send_box(b);
        b = '{1'b1, 20'sd10, 20'sd10, 20'sd170, 20'sd170, 16'd5, 7'd79, 1'b0};
        send_box(b);
        b = '{1'b1, 20'sd50, 20'sd50, 20'sd50, 20'sd50, 16'd9, 7'd3, 1'b0};
        send_box(b);                                   // point box, zero union
        b = '{1'b1, 20'sd50, 20'sd50, 20'sd50, 20'sd50, 16'd8, 7'd3, 1'b0};
        send_box(b);
        b = '{1'b1, 20'sd40, 20'sd40, 20'sd70, 20'sd70, 16'd7, 7'd3, 1'b0};
        send_box(b);
        b = '{1'b1, 20'sd900, 20'sd0, 20'sd100, 20'sd500, 16'd60000, 7'd5, 1'b0};
        send_box(b);                                   // inverted, negative area
        b = '{1'b1, 20'sd200, 20'sd10, 20'sd400, 20'sd300, 16'd50000, 7'd5, 1'b0};
        send_box(b);
        b = '{1'b1, 20'sd20000, 20'sd9000, 20'sd30000, 20'sd9500, 16'd1, 7'd6, 1'b0};
        send_box(b);                                   // clamped to empty
        b = '{1'b1, 20'sd1, 20'sd1, 20'sd2, 20'sd2, 16'd1, 7'd80, 1'b0};
        send_box(b);                                   // bad labels
        b.label = 7'd127;
        b.frame_last = 1'b1;
        send_box(b);
    endtask

    task automatic test_config_extremes();
        int thr_set[4] = '{0, 65535, 32768, 1};
        int dim_set[4] = '{1, 8192, 640, 3000};
        in_item_t b;
        for (int s = 0; s < 4; s++)
        begin
            wait_drained();
            write_reg(CFG_THR, thr_set[s]);
            write_reg(CFG_FW, dim_set[s]);
            write_reg(CFG_FH, dim_set[3-s]);
            for (int i = 0; i < 5; i++)
            begin
                b = make_box($urandom_range(0, 2), 3000, 3000, i == 4);
                send_box(b);
            end
        end
        wait_drained();
        write_reg(CFG_THR, 29491);
        write_reg(CFG_FW, 640);
        write_reg(CFG_FH, 480);
    endtask

    task automatic test_overflow();
        in_item_t b;
        for (int i = 0; i < 35; i++)
        begin
            b = make_box(i % 4, 4000, 2000, i == 34);
            send_box(b);
        end
    endtask

    task automatic test_backpressure();
        in_item_t b;
        wait_drained();
        for (int i = 0; i < 6; i++)
        begin
            b = make_box(i % 2, 500, 500, i == 5);
            send_box(b);
        end
        hold_cycles = 4000;
        for (int i = 0; i < 12; i++)
        begin
            b = make_box(1, 800, 800, i == 11);
            send_box(b);
        end
        wait_drained();
    endtask

    task automatic test_random();
        in_item_t b;
        int sent, len, cls_hi, cx, cy;
        sent = 0;
        while (sent < 150)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drained();
                write_reg(CFG_THR, $urandom_range(0, 65535));
                write_reg(CFG_FW, $urandom_range(1, 8192));
                write_reg(CFG_FH, $urandom_range(1, 8192));
            end
            len = $urandom_range(1, 14);
            cls_hi = $urandom_range(0, 4);
            cx = $urandom_range(0, 60000);
            cy = $urandom_range(0, 60000);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 9))
                    0: b = wild_box(i == len - 1);
                    1:
                    begin
                        b = '0;
                        b.frame_last = (i == len - 1);
                    end
                    default: b = make_box($urandom_range(0, cls_hi) * 19, cx, cy, i == len - 1);
                endcase
                send_box(b);
                sent++;
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        nms_rec_t e;
        out_item_t got;
        if (m_tvalid && m_tready)
        begin
            got = '0;
            got.x_min = m_tdata[19:0];
            got.y_min = m_tdata[39:20];
            got.x_max = m_tdata[59:40];
            got.y_max = m_tdata[79:60];
            got.score = m_tdata[95:80];
            got.label = m_tdata[102:96];
            got.dropped = m_tdata[103];
            got.frame_end = m_tuser;
            if (kept_q.size() == 0)
            begin
                $display("%0t: unexpected word %h user %b last %b", $realtime, m_tdata,
                         m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                e = kept_q.pop_front();
                if (got !== e.rec || m_tlast !== e.last)
                begin
                    $display("%0t: mismatch expected %h last %b, actual %h last %b",
                             $realtime, e.rec, e.last, got, m_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern and long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("per_class_box_nms test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_overflow();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("per_class_box_nms test passed");
        else
            $display("per_class_box_nms test failed");
        $finish;
    end
endmodule
